/* rtl/vscd_pkg.sv */
// ----------------------------------------------------------------------------
// vscd_pkg
// Shared types and constants for the vector sprite command decoder.
// ----------------------------------------------------------------------------
package vscd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 6;
    localparam int unsigned CmdW   = 2;
    localparam int unsigned TdataW = 24;

    localparam logic [ByteW-1:0] OpMask    = 8'hC0;
    localparam logic [ByteW-1:0] CountMask = 8'h3F;

    typedef enum logic [CmdW-1:0] {
        CMD_RESET = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_DRAW  = 2'd2,
        CMD_POINT = 2'd3
    } t_beam_cmd;

    typedef struct packed {
        t_beam_cmd         beam_cmd;
        logic [ByteW-1:0]  delta_y;
        logic [ByteW-1:0]  delta_x;
        logic              run_last;
        logic [CountW-1:0] run_length;
    } t_result;

endpackage

/* rtl/vector_sprite_command_decoder.sv */
// ----------------------------------------------------------------------------
// vector_sprite_command_decoder
// Turns a vector sprite byte stream into beam commands with relative deltas.
//
// Input stream: one sprite byte per word on tdata, tuser set on the first
// byte of a sprite clears the pen and the parse state. Header bytes carry an
// opcode in bits 7..6 and a pair count in bits 5..0; each following (y,x)
// pair is an absolute position.
// Output stream: one command word per reset header and per x byte; tuser is
// the beam command, tdata the y delta, x delta and run length, tlast marks
// the last pair of a run. Other headers and y bytes produce no word.
// An accepted word waits in the input register; its command word goes into the
// result register when the output side is free. One word is accepted every
// cycle while the output side keeps up.
// A stalled receiver holds the result register; the input register then
// fills and tready drops, unless the waiting word produces no output.
// Reset empties both registers and puts the pen at the origin.
// ----------------------------------------------------------------------------
module vector_sprite_command_decoder
    import vscd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [ByteW-1:0]  i_s_tdata,   // [7:0] stream_byte
    input  logic              i_s_tuser,   // [0] sprite_start
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [TdataW-1:0] o_m_tdata,   // [7:0] delta_y, [15:8] delta_x,
                                           // [21:16] run_length, [23:22] zero
    output logic [CmdW-1:0]   o_m_tuser,   // [1:0] beam_cmd
    output logic              o_m_tlast    // run_last
);

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_start;

    logic    emit, step, out_free;
    t_result core_result, out_result;

    assign step       = r_in_valid && (!emit || out_free);
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
    end

    vscd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .o_emit   (emit),
        .o_result (core_result)
    );

    vscd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && emit),
        .i_result (core_result),
        .i_ready  (i_m_tready),
        .o_free   (out_free),
        .o_valid  (o_m_tvalid),
        .o_result (out_result)
    );

    assign o_m_tdata = {2'b00, out_result.run_length, out_result.delta_x, out_result.delta_y};
    assign o_m_tuser = out_result.beam_cmd;
    assign o_m_tlast = out_result.run_last;

endmodule

/* rtl/vscd_core.sv */
// ----------------------------------------------------------------------------
// vscd_core
// Parse state, pen position and per-word decode into beam commands.
// ----------------------------------------------------------------------------
module vscd_core
    import vscd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [ByteW-1:0] i_byte,
    input  logic             i_start,
    output logic             o_emit,
    output t_result          o_result
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_Y      = 2'd1,
        PH_X      = 2'd2
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [ByteW-1:0]  r_pen_y, n_pen_y;
    logic [ByteW-1:0]  r_pen_x, n_pen_x;
    t_beam_cmd         r_op, n_op;
    logic [CountW-1:0] r_pairs, n_pairs;
    logic [CountW-1:0] r_total, n_total;
    logic [ByteW-1:0]  r_held_y, n_held_y;

    t_phase            cur_phase;
    logic [ByteW-1:0]  cur_pen_y, cur_pen_x, cur_held_y;
    logic [CountW-1:0] cur_pairs, dec_pairs, hdr_count;
    t_beam_cmd         hdr_op;

    always_comb begin
        cur_phase  = i_start ? PH_HEADER : r_phase;
        cur_pen_y  = i_start ? '0 : r_pen_y;
        cur_pen_x  = i_start ? '0 : r_pen_x;
        cur_pairs  = i_start ? '0 : r_pairs;
        cur_held_y = i_start ? '0 : r_held_y;
        dec_pairs  = cur_pairs - CountW'(1);
        hdr_op     = t_beam_cmd'(CmdW'((i_byte & OpMask) >> (ByteW - CmdW)));
        hdr_count  = CountW'(i_byte & CountMask);

        n_phase  = cur_phase;
        n_pen_y  = cur_pen_y;
        n_pen_x  = cur_pen_x;
        n_op     = r_op;
        n_pairs  = cur_pairs;
        n_total  = r_total;
        n_held_y = cur_held_y;
        o_emit   = 1'b0;
        o_result = '0;

        unique case (cur_phase)
            PH_Y: begin
                n_held_y = i_byte;
                n_phase  = PH_X;
            end
            PH_X: begin
                o_emit              = 1'b1;
                o_result.beam_cmd   = r_op;
                o_result.delta_y    = cur_held_y - cur_pen_y;
                o_result.delta_x    = i_byte - cur_pen_x;
                o_result.run_last   = (dec_pairs == '0);
                o_result.run_length = r_total;
                n_pen_y             = cur_held_y;
                n_pen_x             = i_byte;
                n_pairs             = dec_pairs;
                n_phase             = (dec_pairs == '0) ? PH_HEADER : PH_Y;
            end
            default: begin
                n_phase = PH_HEADER;
                if (hdr_op == CMD_RESET) begin
                    o_emit   = 1'b1;
                    n_pen_y  = '0;
                    n_pen_x  = '0;
                    n_op     = CMD_RESET;
                end else if (hdr_count != '0) begin
                    n_op    = hdr_op;
                    n_pairs = hdr_count;
                    n_total = hdr_count;
                    n_phase = PH_Y;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pen_y  <= '0;
            r_pen_x  <= '0;
            r_op     <= CMD_RESET;
            r_pairs  <= '0;
            r_total  <= '0;
            r_held_y <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_pen_y  <= n_pen_y;
            r_pen_x  <= n_pen_x;
            r_op     <= n_op;
            r_pairs  <= n_pairs;
            r_total  <= n_total;
            r_held_y <= n_held_y;
        end
    end

endmodule

/* rtl/vscd_out_reg.sv */
// ----------------------------------------------------------------------------
// vscd_out_reg
// Result register holding one command word for the output stream.
// ----------------------------------------------------------------------------
module vscd_out_reg
    import vscd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
